// File: design/scancode_to_ascii_keyboard_fifo_core_macros.svh
// assertion macros for the scancode to ascii core
`ifndef SCANCODE_TO_ASCII_KEYBOARD_FIFO_CORE_MACROS_SVH
`define SCANCODE_TO_ASCII_KEYBOARD_FIFO_CORE_MACROS_SVH

// same-cycle implication, checked only out of reset
`define SC2A_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sc2a same-cycle check failed");

// next-cycle implication, checked only out of reset
`define SC2A_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sc2a next-cycle check failed");

`endif

// File: design/sc2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_pkg
// types, constants and key tables for the set-1 scancode to ascii core
// ----------------------------------------------------------------------------
package sc2a_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [7:0] BREAK_BIT = 8'h80;
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CAPS   = 7'h3A;
    localparam logic [7:0] MAP_LEN   = 8'd58;

    localparam logic OP_SCANCODE = 1'b0;
    localparam logic OP_READ     = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] scancode;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       fifo_empty;
    } out_beat_t;

    // row index is {layout, shifted}: azerty, azerty shifted, qwerty, qwerty shifted
    localparam logic [7:0] KEY_MAP [4][58] = '{
        '{8'h00, 8'h1B, 8'h26, 8'h82, 8'h22, 8'h27, 8'h28, 8'h2D, 8'h8A, 8'h5F,
          8'h87, 8'h85, 8'h29, 8'h3D, 8'h08, 8'h09, 8'h61, 8'h7A, 8'h65, 8'h72,
          8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5E, 8'h24, 8'h0A, 8'h00,
          8'h71, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h6D,
          8'h97, 8'h88, 8'h00, 8'h2A, 8'h77, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
          8'h2C, 8'h3B, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20},
        '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
          8'h39, 8'h30, 8'hB0, 8'h2B, 8'h08, 8'h09, 8'h41, 8'h5A, 8'h45, 8'h52,
          8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'hA8, 8'hA3, 8'h0A, 8'h00,
          8'h51, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h4D,
          8'h25, 8'hB5, 8'h00, 8'h2A, 8'h57, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
          8'h3F, 8'h2E, 8'h2F, 8'hA7, 8'h00, 8'h2A, 8'h00, 8'h20},
        '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
          8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
          8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
          8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
          8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
          8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20},
        '{8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
          8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
          8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
          8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
          8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
          8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20}
    };

    // ring pointer advance, wraps at the fifo depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

// File: design/scancode_to_ascii_keyboard_fifo_core.sv
`timescale 1ns / 1ps
// a scancode beat updates shift, caps and the fifo when accepted; a read of an empty
// fifo loads its result beat straight into the output register, while a read that pops
// a character first passes the pending-read flag and the registered memory read port
// throughput: 1 scancode per cycle while no memory read is in flight; reads wait too
// reset: aresetn (synchronous, active low) clears pointers, shift, caps, layout, pending read and output valid;
// the character memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// scancode_to_ascii_keyboard_fifo_core
// set-1 scancode to ascii translation with a ring fifo of characters
// ----------------------------------------------------------------------------
`include "scancode_to_ascii_keyboard_fifo_core_macros.svh"

module scancode_to_ascii_keyboard_fifo_core (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write channel: layout select
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_layout_select,
    // input beat: scancode or read request
    input  logic                s_valid,
    output logic                s_ready,
    input  sc2a_pkg::in_beat_t  s_data,
    // result beat: popped character or empty flag
    output logic                m_valid,
    input  logic                m_ready,
    output sc2a_pkg::out_beat_t m_data
);
    import sc2a_pkg::*;

    // character memory, one write and one registered read port
    logic [7:0]       char_mem [FIFO_DEPTH];
    logic [7:0]       rdata_reg;

    // control state
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             shift_reg, shift_next;
    logic             caps_reg, caps_next;
    logic             layout_reg, layout_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_data_reg, m_data_next;

    // decode
    logic             accept;
    logic             out_free;
    logic             is_make;
    logic             is_shift;
    logic             is_caps;
    logic             in_map;
    logic [7:0]       key_char;
    logic             fifo_empty;
    logic             fifo_full;
    logic             push;
    logic             pop;

    // config is always taken; the user must write it only while the core is idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    // output register is free when empty or draining this cycle
    assign out_free = !m_valid_reg || m_ready;

    // a read needs room for its result beat; a scancode never does
    // nothing is taken while a memory read is in flight
    assign s_ready = !rd_pend_reg && ((s_data.opcode == OP_SCANCODE) || out_free);
    assign accept  = s_valid && s_ready;

    // scancode classification, break bit split off
    assign is_make  = (s_data.scancode & BREAK_BIT) == 8'h00;
    assign is_shift = (s_data.scancode[6:0] == SC_LSHIFT) ||
                      (s_data.scancode[6:0] == SC_RSHIFT);
    assign is_caps  = s_data.scancode[6:0] == SC_CAPS;
    assign in_map   = s_data.scancode < MAP_LEN;

    // table row picks layout and shifted level (shift xor caps)
    assign key_char = KEY_MAP[{layout_reg, shift_reg ^ caps_reg}][s_data.scancode[5:0]];

    // one slot stays free to tell full from empty
    assign fifo_empty = wr_ptr_reg == rd_ptr_reg;
    assign fifo_full  = ptr_inc(wr_ptr_reg) == rd_ptr_reg;

    // push a nonzero mapped code unless full, pop only when something waits
    assign push = accept && (s_data.opcode == OP_SCANCODE) && is_make && !is_shift &&
                  !is_caps && in_map && (key_char != 8'h00) && !fifo_full;
    assign pop  = accept && (s_data.opcode == OP_READ) && !fifo_empty;

    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        shift_next   = shift_reg;
        caps_next    = caps_reg;
        layout_next  = layout_reg;
        rd_pend_next = 1'b0;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            layout_next = cfg_layout_select;
        end

        // shift make sets, shift break clears, caps make toggles
        if (accept && (s_data.opcode == OP_SCANCODE) && is_shift) begin
            shift_next = is_make;
        end
        if (accept && (s_data.opcode == OP_SCANCODE) && is_make && is_caps) begin
            caps_next = !caps_reg;
        end

        if (push) begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end

        // retire the result beat first, a new load below overrides it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (rd_pend_reg) begin
            // the memory data registered by the pop is loaded into the result beat
            m_valid_next          = 1'b1;
            m_data_next.char_byte = rdata_reg;
            m_data_next.fifo_empty = 1'b0;
        end else if (pop) begin
            rd_ptr_next  = ptr_inc(rd_ptr_reg);
            rd_pend_next = 1'b1;
        end else if (accept && (s_data.opcode == OP_READ)) begin
            // read of an empty fifo loads its answer straight into the result beat
            m_valid_next           = 1'b1;
            m_data_next.char_byte  = 8'h00;
            m_data_next.fifo_empty = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            shift_reg   <= 1'b0;
            caps_reg    <= 1'b0;
            layout_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            shift_reg   <= shift_next;
            caps_reg    <= caps_next;
            layout_reg  <= layout_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // character memory: write at the write pointer, registered read at the read pointer
    always_ff @(posedge aclk) begin
        if (push) begin
            char_mem[wr_ptr_reg] <= key_char;
        end
        if (pop) begin
            rdata_reg <= char_mem[rd_ptr_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // no new beat while the memory read is in flight
    `SC2A_ASSERT_IMPL(a_pend_blocks_input, rd_pend_reg, !s_ready)
    // a pending read always loads a non-empty result beat on the following cycle
    `SC2A_ASSERT_NEXT(a_pend_loads_output, rd_pend_reg, m_valid_reg && !m_data_reg.fifo_empty)
    // an empty answer carries a zero character
    `SC2A_ASSERT_IMPL(a_empty_is_zero, m_valid_reg && m_data_reg.fifo_empty,
                      m_data_reg.char_byte == 8'h00)
    // a pop never happens from an empty fifo
    `SC2A_ASSERT_IMPL(a_no_pop_when_empty, pop, !fifo_empty)

endmodule

// File: tb/tb_scancode_to_ascii_keyboard_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scancode_to_ascii_keyboard_fifo_core
// self-checking bench for the set-1 scancode to ascii core: scancode and read
// beats go in through valid/ready with random gaps, a keyboard predictor kept
// in a small scoreboard tracks shift, caps lock, layout and the character
// fifo, and every result beat is compared with the oldest predicted read
// ----------------------------------------------------------------------------
module tb_scancode_to_ascii_keyboard_fifo_core;

    import sc2a_pkg::*;

    // key codes as the predictor sees them (make form, break bit stripped)
    localparam logic [6:0] KEY_SHIFT_L = 7'h2A;
    localparam logic [6:0] KEY_SHIFT_R = 7'h36;
    localparam logic [6:0] KEY_CAPS    = 7'h3A;
    localparam logic [7:0] KEY_RELEASE = 8'h80;
    localparam int         KEYS_MAPPED = 58;
    // one ring slot always stays free
    localparam int         CHAR_ROOM   = FIFO_DEPTH - 1;

    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;

    // character tables, row is {layout, shifted}:
    // azerty, azerty shifted, qwerty, qwerty shifted
    localparam logic [7:0] CHAR_TABLE [4][58] = '{
        '{8'h00, 8'h1B, 8'h26, 8'h82, 8'h22, 8'h27, 8'h28, 8'h2D, 8'h8A, 8'h5F,
          8'h87, 8'h85, 8'h29, 8'h3D, 8'h08, 8'h09, 8'h61, 8'h7A, 8'h65, 8'h72,
          8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5E, 8'h24, 8'h0A, 8'h00,
          8'h71, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h6D,
          8'h97, 8'h88, 8'h00, 8'h2A, 8'h77, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
          8'h2C, 8'h3B, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20},
        '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
          8'h39, 8'h30, 8'hB0, 8'h2B, 8'h08, 8'h09, 8'h41, 8'h5A, 8'h45, 8'h52,
          8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'hA8, 8'hA3, 8'h0A, 8'h00,
          8'h51, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h4D,
          8'h25, 8'hB5, 8'h00, 8'h2A, 8'h57, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
          8'h3F, 8'h2E, 8'h2F, 8'hA7, 8'h00, 8'h2A, 8'h00, 8'h20},
        '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
          8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
          8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
          8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
          8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
          8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20},
        '{8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
          8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
          8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
          8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
          8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
          8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20}
    };

    // opening beats: empty read, shift and caps combinations, keys with no
    // character, ignored breaks, the last mapped key, then a few reads
    localparam in_beat_t OPENING [25] = '{
        '{OP_READ, 8'hFF},     '{OP_SCANCODE, 8'h10}, '{OP_SCANCODE, 8'h2A},
        '{OP_SCANCODE, 8'h10}, '{OP_SCANCODE, 8'hAA}, '{OP_SCANCODE, 8'h36},
        '{OP_SCANCODE, 8'h02}, '{OP_SCANCODE, 8'hB6}, '{OP_SCANCODE, 8'h3A},
        '{OP_SCANCODE, 8'h10}, '{OP_SCANCODE, 8'hBA}, '{OP_SCANCODE, 8'h2A},
        '{OP_SCANCODE, 8'h03}, '{OP_SCANCODE, 8'hAA}, '{OP_SCANCODE, 8'h3A},
        '{OP_SCANCODE, 8'h00}, '{OP_SCANCODE, 8'h1D}, '{OP_SCANCODE, 8'h3B},
        '{OP_SCANCODE, 8'h7F}, '{OP_SCANCODE, 8'h80}, '{OP_SCANCODE, 8'h39},
        '{OP_READ, 8'h00},     '{OP_READ, 8'h55},     '{OP_READ, 8'hAA},
        '{OP_READ, 8'h7F}
    };

    // keyboard predictor and store of predicted read results
    class keyboard_scoreboard;
        logic [7:0] typed_chars[$];
        out_beat_t  expected_reads[$];
        logic       layout_qwerty;
        logic       shift_held;
        logic       caps_on;
        int         errors;

        function new();
            layout_qwerty = 1'b0;
            shift_held    = 1'b0;
            caps_on       = 1'b0;
            errors        = 0;
        endfunction

        function void set_layout(logic qwerty);
            layout_qwerty = qwerty;
        endfunction

        // apply one accepted beat to the predicted keyboard state
        function void apply_keyboard_beat(in_beat_t beat);
            logic [6:0] base;
            logic [7:0] ch;
            out_beat_t  res;
            base = beat.scancode[6:0];
            if (beat.opcode == OP_READ) begin
                if (typed_chars.size() == 0) begin
                    res.char_byte  = 8'h00;
                    res.fifo_empty = 1'b1;
                end else begin
                    res.char_byte  = typed_chars.pop_front();
                    res.fifo_empty = 1'b0;
                end
                expected_reads.push_back(res);
            end else if (beat.scancode[7]) begin
                if (base == KEY_SHIFT_L || base == KEY_SHIFT_R) begin
                    shift_held = 1'b0;
                end
            end else if (base == KEY_SHIFT_L || base == KEY_SHIFT_R) begin
                shift_held = 1'b1;
            end else if (base == KEY_CAPS) begin
                caps_on = !caps_on;
            end else if (beat.scancode < KEYS_MAPPED) begin
                ch = CHAR_TABLE[{layout_qwerty, shift_held ^ caps_on}][beat.scancode];
                if (ch != 8'h00 && typed_chars.size() < CHAR_ROOM) begin
                    typed_chars.push_back(ch);
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_read_result(out_beat_t got);
            out_beat_t want;
            if (expected_reads.size() == 0) begin
                report_mismatch($sformatf("result beat with no read pending (char %02h empty %0b)",
                                          got.char_byte, got.fifo_empty));
                return;
            end
            want = expected_reads.pop_front();
            if (got.char_byte !== want.char_byte) begin
                report_mismatch($sformatf("char_byte %02h, predicted %02h",
                                          got.char_byte, want.char_byte));
            end
            if (got.fifo_empty !== want.fifo_empty) begin
                report_mismatch($sformatf("fifo_empty %0b, predicted %0b",
                                          got.fifo_empty, want.fifo_empty));
            end
        endtask
    endclass

    logic      aclk;
    logic      aresetn;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_layout_select;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    keyboard_scoreboard board = new();

    // idle rates in percent of cycles, changed between phases
    int s_idle_pct  = 0;
    int m_stall_pct = 0;
    int quiet_cycles = 0;

    scancode_to_ascii_keyboard_fifo_core uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_layout_select (cfg_layout_select),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data            (s_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_stall_pct);
    end

    // one place watches all three channels so the predictor applies an input
    // beat before any result beat that is taken in the same cycle
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                board.set_layout(cfg_layout_select);
            end
            if (s_valid && s_ready) begin
                board.apply_keyboard_beat(s_data);
            end
            if (m_valid && m_ready) begin
                board.check_read_result(m_data);
            end
        end
    end

    // watchdog: too long without any handshake means the block is stuck
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // offer one beat, with random sender gaps in front, and hold it until taken
    task automatic send_beat(in_beat_t beat);
        @(negedge aclk);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_key(logic [7:0] code);
        send_beat('{OP_SCANCODE, code});
    endtask

    // the scancode field of a read carries random bits, the block ignores it
    task automatic send_read();
        send_beat('{OP_READ, 8'($urandom_range(255))});
    endtask

    // drop valid, then wait until every predicted read has come back plus a
    // settling wait for scancode beats still in flight
    task automatic finish_phase();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.expected_reads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_layout(logic qwerty);
        @(negedge aclk);
        cfg_valid         <= 1'b1;
        cfg_layout_select <= qwerty;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly typing: key strokes with make and break, sometimes under shift,
    // caps toggles and reads in between, plus some raw noise beats
    task automatic type_randomly(int beat_count);
        int         sent;
        int         pick;
        int         nkeys;
        bit         hold_shift;
        logic [7:0] shift_key;
        logic [7:0] code;
        sent = 0;
        while (sent < beat_count) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                hold_shift = ($urandom_range(2) == 0);
                shift_key  = {1'b0, ($urandom_range(1) ? KEY_SHIFT_L : KEY_SHIFT_R)};
                if (hold_shift) begin
                    send_key(shift_key);
                    sent++;
                end
                nkeys = $urandom_range(4, 1);
                repeat (nkeys) begin
                    code = 8'($urandom_range(KEYS_MAPPED - 1));
                    send_key(code);
                    send_key(code | KEY_RELEASE);
                    sent += 2;
                    if ($urandom_range(1)) begin
                        send_read();
                        sent++;
                    end
                end
                if (hold_shift) begin
                    send_key(shift_key | KEY_RELEASE);
                    sent++;
                end
            end else if (pick < 65) begin
                send_key({1'b0, KEY_CAPS});
                send_key({1'b0, KEY_CAPS} | KEY_RELEASE);
                sent += 2;
            end else if (pick < 80) begin
                repeat ($urandom_range(5, 1)) begin
                    send_read();
                    sent++;
                end
            end else begin
                send_beat(in_beat_t'(9'($urandom_range(511))));
                sent++;
            end
        end
    endtask

    initial begin
        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_layout_select = 1'b0;
        s_valid           = 1'b0;
        s_data            = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // phase 1: busy sender, mostly stalled receiver
        s_idle_pct  = 18;
        m_stall_pct = 85;
        // opening beats run on the reset layout
        foreach (OPENING[i]) begin
            send_beat(OPENING[i]);
        end
        finish_phase();
        write_layout(1'b1);
        type_randomly(430);
        finish_phase();

        // phase 2: mostly idle sender, eager receiver; overfill the fifo so
        // characters get dropped, then drain it past empty
        s_idle_pct  = 85;
        m_stall_pct = 18;
        write_layout(1'b0);
        repeat (CHAR_ROOM + 25) begin
            send_key(8'($urandom_range(8'h19, 8'h10)));
        end
        repeat (CHAR_ROOM + 5) begin
            send_read();
        end
        type_randomly(430);
        finish_phase();

        // phase 3: back to back in both directions
        s_idle_pct  = 0;
        m_stall_pct = 0;
        write_layout(1'b1);
        type_randomly(430);
        finish_phase();

        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
